// ===== hw/rtl/anep_pkg.sv =====
// Shared types and constants for the ASCII number entry parser.
`timescale 1ns / 1ps

package anep_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int COUNT_WIDTH     = 32;
  localparam int NUMBER_WIDTH    = 32;

  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_BS  = 8'd8;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;
  localparam logic [7:0] CHAR_UA  = 8'h41;
  localparam logic [7:0] CHAR_UF  = 8'h46;
  localparam logic [7:0] CHAR_LA  = 8'h61;
  localparam logic [7:0] CHAR_LF  = 8'h66;

  localparam logic [3:0] HEX_TEN   = 4'hA;
  localparam logic [4:0] DEC_RADIX = 5'd10;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_DIGIT,
    OP_BACK,
    OP_RETURN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       hex;
    logic [3:0] digit;
    logic [7:0] ch;
  } cmd_t;

  typedef enum logic {
    BK_RUN,
    BK_DIV
  } back_state_t;

endpackage

// ===== hw/rtl/anep_ifs.sv =====
// Valid/ready channel interfaces for characters in and results out.
`timescale 1ns / 1ps

interface anep_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source(output valid, output char_in, input ready);
  modport sink(input valid, input char_in, output ready);
endinterface

interface anep_result_if;
  logic        valid;
  logic        ready;
  logic        echo_valid;
  logic [7:0]  echo_char;
  logic        entry_done;
  logic [31:0] number_out;

  modport source(output valid, output echo_valid, output echo_char,
                 output entry_done, output number_out, input ready);
  modport sink(input valid, input echo_valid, input echo_char,
               input entry_done, input number_out, output ready);
endinterface

// ===== hw/rtl/anep_front.sv =====
// Front end: radix mode register and character classification.
`timescale 1ns / 1ps

module anep_front import anep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  anep_char_if.sink   char_stream,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_data
);

  logic radix_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_mode <= 1'b0;
    end else if (cfg_we) begin
      radix_mode <= cfg_wdata;
    end
  end

  assign char_stream.ready = !q_full;
  assign q_push            = char_stream.valid && !q_full;

  always_comb begin
    logic [7:0] c;
    c           = char_stream.char_in;
    q_data.op    = OP_NONE;
    q_data.hex   = radix_mode;
    q_data.digit = 4'd0;
    q_data.ch    = c;
    if (c == CHAR_CR) begin
      q_data.op = OP_RETURN;
    end else if (c >= CHAR_0 && c <= CHAR_9) begin
      q_data.op    = OP_DIGIT;
      q_data.digit = 4'(c - CHAR_0);
    end else if (radix_mode && c >= CHAR_UA && c <= CHAR_UF) begin
      q_data.op    = OP_DIGIT;
      q_data.digit = 4'(c - CHAR_UA) + HEX_TEN;
    end else if (radix_mode && c >= CHAR_LA && c <= CHAR_LF) begin
      q_data.op    = OP_DIGIT;
      q_data.digit = 4'(c - CHAR_LA) + HEX_TEN;
    end else if (c == CHAR_BS) begin
      q_data.op = OP_BACK;
    end
  end

endmodule

// ===== hw/rtl/anep_queue.sv =====
// Small command queue between the front and back ends.
`timescale 1ns / 1ps

module anep_queue import anep_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign full      = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      case ({push, pop})
        2'b10:   fill <= CW'(fill + 1'b1);
        2'b01:   fill <= CW'(fill - 1'b1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hw/rtl/anep_div10.sv =====
// Divide-by-ten unit: shift-and-add reciprocal estimate with a final correction.
`timescale 1ns / 1ps

module anep_div10 import anep_pkg::*; #(
  parameter int W = VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  output logic [W-1:0] quotient,
  output logic         done
);

  logic [W-1:0] num;
  logic [W-1:0] est;
  logic [W-1:0] est1_a;
  logic [W-1:0] est1;
  logic [W-1:0] est2_a;
  logic [W-1:0] est2_b;
  logic [W-1:0] est2;
  logic [W-1:0] q_lo;
  logic [W-1:0] rem;
  logic         busy;
  logic         refined;

  // est approaches 0.8 * n; est / 8 is then n / 10, low by at most one
  assign est1_a = (dividend >> 1) + (dividend >> 2);
  assign est1   = est1_a + (est1_a >> 4);
  assign est2_a = est + (est >> 8);
  assign est2_b = est2_a + (est2_a >> 16);
  // the 32-bit step only adds something for widths above 32
  assign est2   = est2_b + (est2_b >> 32);
  assign q_lo   = est >> 3;
  assign rem    = num - ((q_lo << 3) + (q_lo << 1));

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      est <= est1;
    end else if (busy && !refined) begin
      est <= est2;
    end else if (busy) begin
      quotient <= q_lo + {{(W-1){1'b0}}, (rem >= W'(DEC_RADIX))};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      refined <= 1'b0;
      done    <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      refined <= 1'b0;
      done    <= 1'b0;
    end else if (busy && !refined) begin
      refined <= 1'b1;
    end else if (busy) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/anep_back.sv =====
// Back end: accumulator and digit count update, result output register.
`timescale 1ns / 1ps

module anep_back import anep_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  cmd_t           q_data,
  output logic           q_pop,
  anep_result_if.source  result_stream
);

  localparam int W = VALUE_WIDTH;

  back_state_t            state;
  back_state_t            state_next;
  logic [W-1:0]           acc;
  logic [W-1:0]           acc_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;

  logic                    out_vld;
  logic                    out_echo;
  logic [7:0]              out_char;
  logic                    out_done;
  logic [NUMBER_WIDTH-1:0] out_num;

  logic         can_load;
  logic         load;
  logic         r_echo;
  logic [7:0]   r_char;
  logic         r_done;
  logic [W-1:0] r_acc;
  logic [63:0]  r_ext;

  logic         div_start;
  logic [W-1:0] div_quot;
  logic         div_done;

  anep_div10 #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .quotient (div_quot),
    .done     (div_done)
  );

  assign can_load = !out_vld || result_stream.ready;

  always_comb begin
    state_next = state;
    acc_next   = acc;
    count_next = count;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    load       = 1'b0;
    r_echo     = 1'b0;
    r_char     = 8'd0;
    r_done     = 1'b0;
    case (state)
      BK_RUN: begin
        if (q_valid && can_load) begin
          q_pop = 1'b1;
          case (q_data.op)
            OP_RETURN: begin
              load       = 1'b1;
              r_done     = 1'b1;
              acc_next   = '0;
              count_next = '0;
            end
            OP_DIGIT: begin
              load   = 1'b1;
              r_echo = 1'b1;
              r_char = q_data.ch;
              if (q_data.hex) begin
                acc_next = {acc[W-5:0], q_data.digit};
              end else begin
                acc_next = W'((acc << 3) + (acc << 1) + {{(W-4){1'b0}}, q_data.digit});
              end
              count_next = COUNT_WIDTH'(count + 1'b1);
            end
            OP_BACK: begin
              if (count == '0) begin
                load = 1'b1;
              end else if (q_data.hex) begin
                load       = 1'b1;
                r_echo     = 1'b1;
                r_char     = CHAR_BS;
                acc_next   = acc >> 4;
                count_next = COUNT_WIDTH'(count - 1'b1);
              end else begin
                div_start  = 1'b1;
                state_next = BK_DIV;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      BK_DIV: begin
        if (div_done && can_load) begin
          load       = 1'b1;
          r_echo     = 1'b1;
          r_char     = CHAR_BS;
          acc_next   = div_quot;
          count_next = COUNT_WIDTH'(count - 1'b1);
          state_next = BK_RUN;
        end
      end
      default: begin
        state_next = BK_RUN;
      end
    endcase
    // carriage return reports the value from before the clear
    r_acc = r_done ? acc : acc_next;
    r_ext = 64'(r_acc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_RUN;
      acc     <= '0;
      count   <= '0;
      out_vld <= 1'b0;
    end else begin
      state <= state_next;
      acc   <= acc_next;
      count <= count_next;
      if (load) begin
        out_vld <= 1'b1;
      end else if (result_stream.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_echo <= r_echo;
      out_char <= r_char;
      out_done <= r_done;
      out_num  <= r_ext[NUMBER_WIDTH-1:0];
    end
  end

  assign result_stream.valid      = out_vld;
  assign result_stream.echo_valid = out_echo;
  assign result_stream.echo_char  = out_char;
  assign result_stream.entry_done = out_done;
  assign result_stream.number_out = out_num;

endmodule

// ===== hw/rtl/ascii_number_entry_parser.sv =====
// Top level of the ASCII number entry parser.
//
//   channel        dir  payload                                        modport
//   char_stream    in   char_in[7:0]                                   sink
//   result_stream  out  echo_valid, echo_char[7:0], entry_done,
//                       number_out[31:0]                               source
//   cfg_we/wdata   in   radix_mode (1 bit)                             --
//
// One character per cycle sustained unless output stalls or a divide runs;
// the back end pops a character the cycle after its transfer and registers its
// result for transfer out. Decimal backspace with digits entered holds the back
// end for a pop, two divide-by-ten steps and a result load instead of one pop.
// The queue lets characters keep arriving while the back end divides or stalls.
// Synchronous reset clears mode, accumulator, digit count and queue.
`timescale 1ns / 1ps

module ascii_number_entry_parser import anep_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  anep_char_if.sink     char_stream,
  anep_result_if.source result_stream
);

  logic q_push;
  cmd_t q_push_data;
  logic q_full;
  logic q_pop;
  cmd_t q_pop_data;
  logic q_valid;

  anep_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .char_stream (char_stream),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  anep_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_valid)
  );

  anep_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_pop_data),
    .q_pop         (q_pop),
    .result_stream (result_stream)
  );

endmodule
